// ----- sv/displacement_map_warp_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the displacement map warp block.
// Each macro checks one implication on the rising clock edge, with the
// check disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DISPLACEMENT_MAP_WARP_ASSERT_SVH
`define DISPLACEMENT_MAP_WARP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define DMW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("displacement_map_warp: same-cycle check failed");
// Next-cycle implication.
`define DMW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("displacement_map_warp: next-cycle check failed");
`else
`define DMW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DMW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/dmw_pkg.sv -----
// ----------------------------------------------------------------------------
// dmw_pkg
// Shared types and constants of the displacement map warp block.
// ----------------------------------------------------------------------------
`default_nettype none

package dmw_pkg;

    // Item modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HORIZ    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VERT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_SRC    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VERT_SRC     = 3'd5;

    // Map channel selections; every other code selects luminance.
    localparam logic [2:0] SEL_RED   = 3'd0;
    localparam logic [2:0] SEL_GREEN = 3'd1;
    localparam logic [2:0] SEL_BLUE  = 3'd2;
    localparam logic [2:0] SEL_ALPHA = 3'd3;

    // Luminance weights over 256.
    localparam logic [15:0] LUMA_WR = 16'd77;
    localparam logic [15:0] LUMA_WG = 16'd150;
    localparam logic [15:0] LUMA_WB = 16'd29;

    // Full scale of an 8.8 channel value (255 * 256).
    localparam logic signed [17:0] FULL_SCALE = 18'sd65280;

    // Bias that makes the scaled product non-negative before the divide by 255.
    localparam int            DIV_BIAS_Q = 1024;
    localparam logic signed [20:0] DIV_BIAS = 21'sd261120;

    // Pixel word width.
    localparam int PIX_W = 32;

    // Load enables of the offset pipeline stages.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_adv;

endpackage

`default_nettype wire

// ----- sv/dmw_frame_mem.sv -----
// ----------------------------------------------------------------------------
// dmw_frame_mem
// Frame store: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dmw_frame_mem import dmw_pkg::*; #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [PIX_W-1:0] i_wdata,
    input  wire logic             i_re_a,
    input  wire logic [AW-1:0]    i_raddr_a,
    output logic      [PIX_W-1:0] o_rdata_a,
    input  wire logic             i_re_b,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [PIX_W-1:0] o_rdata_b
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rdata_a;
    logic [PIX_W-1:0] r_rdata_b;

    // Write port and both read ports; read data holds while its enable is low.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ----- sv/dmw_offset.sv -----
// ----------------------------------------------------------------------------
// dmw_offset
// Turns the map pixel into a biased whole-pixel offset for one axis.
// ----------------------------------------------------------------------------
`default_nettype none

module dmw_offset import dmw_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic [PIX_W-1:0]   i_pixel,
    input  wire logic [2:0]         i_sel,
    input  wire logic signed [10:0] i_max,
    input  wire t_adv               i_adv,
    output logic      [11:0]        o_qc
);

    logic [7:0]         w_r;
    logic [7:0]         w_g;
    logic [7:0]         w_b;
    logic [7:0]         w_a;
    logic [15:0]        w_luma;
    logic [15:0]        w_v;
    logic signed [17:0] w_t;
    logic signed [28:0] w_prod;
    logic signed [20:0] w_m;
    logic [18:0]        w_mp;
    logic [27:0]        w_x257;
    logic [19:0]        w_rem;
    logic [11:0]        n_qc;

    logic signed [17:0] r_t;
    logic signed [28:0] r_prod;
    logic [18:0]        r_mp;
    logic [11:0]        r_qe;
    logic [11:0]        r_qc;

    // Channel value in 8.8 fixed point, then centered around zero.
    assign w_r    = i_pixel[7:0];
    assign w_g    = i_pixel[15:8];
    assign w_b    = i_pixel[23:16];
    assign w_a    = i_pixel[31:24];
    assign w_luma = LUMA_WR * {8'd0, w_r} + LUMA_WG * {8'd0, w_g} + LUMA_WB * {8'd0, w_b};

    always_comb begin
        case (i_sel)
            SEL_RED:   w_v = {w_r, 8'h00};
            SEL_GREEN: w_v = {w_g, 8'h00};
            SEL_BLUE:  w_v = {w_b, 8'h00};
            SEL_ALPHA: w_v = {w_a, 8'h00};
            default:   w_v = w_luma;
        endcase
    end

    assign w_t = $signed({1'b0, w_v, 1'b0}) - FULL_SCALE;

    // Scale by the largest displacement.
    assign w_prod = 29'(r_t) * 29'(i_max);

    // Floor divide by 256 is an arithmetic shift; the bias keeps the value
    // non-negative so the divide by 255 works on an unsigned number.
    assign w_m    = 21'(r_prod >>> 8);
    assign w_mp   = 19'(w_m + DIV_BIAS);
    assign w_x257 = {9'd0, w_mp} + {1'b0, w_mp, 8'd0};

    // The reciprocal estimate is low by at most one; fix it with the remainder.
    assign w_rem = 20'(r_mp) - {r_qe, 8'd0} + 20'(r_qe);
    assign n_qc  = (w_rem >= 20'd255) ? (r_qe + 12'd1) : r_qe;

    // Stage registers advance with the shared pipeline.
    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_t <= w_t;
        end
        if (i_adv.s3) begin
            r_prod <= w_prod;
        end
        if (i_adv.s4) begin
            r_mp <= w_mp;
            r_qe <= w_x257[27:16];
        end
        if (i_adv.s5) begin
            r_qc <= n_qc;
        end
    end

    assign o_qc = r_qc;

endmodule

`default_nettype wire

// ----- sv/displacement_map_warp.sv -----
// ----------------------------------------------------------------------------
// displacement_map_warp
// Displacement map warp over one RGBA frame held in on-chip memory.
// ----------------------------------------------------------------------------
// The block accepts one item per cycle while o_in_stall is low. A load writes
// its pixel into the frame memory in the cycle of its transfer; a query reads
// its map pixel through the first read port, runs a four-stage offset pipeline
// and reads the source pixel through the second read port into the last stage,
// from which its result leaves when the output is not stalled. Queries stream
// back to back.
// A load that follows queries waits until every earlier query has made its
// second read, which keeps each query on the frame as it was loaded. Loads and
// queries outside the active frame are dropped; a query there gives no result.
// The frame memory has no reset and must be loaded before it is queried.
`default_nettype none

`include "displacement_map_warp_assert.svh"

module displacement_map_warp import dmw_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_mode,
    input  wire logic [7:0]            i_pos_x,
    input  wire logic [7:0]            i_pos_y,
    input  wire logic [7:0]            i_in_red,
    input  wire logic [7:0]            i_in_green,
    input  wire logic [7:0]            i_in_blue,
    input  wire logic [7:0]            i_in_alpha,
    // Output channel.
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [7:0]                 o_out_x,
    output logic [7:0]                 o_out_y,
    output logic [7:0]                 o_out_red,
    output logic [7:0]                 o_out_green,
    output logic [7:0]                 o_out_blue,
    output logic [7:0]                 o_out_alpha
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NST   = 6;

    localparam logic [12:0]   LP_MAXW = 13'(MAX_WIDTH);
    localparam logic [12:0]   LP_MAXH = 13'(MAX_HEIGHT);
    localparam logic [8:0]    LP_W_RST = (MAX_WIDTH < 256) ? 9'(MAX_WIDTH) : 9'd256;
    localparam logic [8:0]    LP_H_RST = (MAX_HEIGHT < 256) ? 9'(MAX_HEIGHT) : 9'd256;
    localparam logic [AW-1:0] LP_ROW = AW'(MAX_WIDTH);

    // Configuration registers; the frame size is kept in its effective form.
    logic [8:0]         r_w;
    logic [8:0]         r_h;
    logic signed [10:0] r_max_h;
    logic signed [10:0] r_max_v;
    logic [2:0]         r_sel_h;
    logic [2:0]         r_sel_v;

    // Pipeline stage registers.
    logic [NST:1] r_v;
    logic [7:0]   r_x [NST:1];
    logic [7:0]   r_y [NST:1];

    logic [NST:1]     w_en;
    logic             w_acc;
    logic             w_inframe;
    logic             w_pending;
    logic             w_wr;
    logic             w_q0;
    logic [AW-1:0]    w_addr_in;
    logic [AW-1:0]    w_addr_src;
    logic [PIX_W-1:0] w_wdata;
    logic [PIX_W-1:0] w_map;
    logic [PIX_W-1:0] w_src;
    logic [11:0]      w_qc_h;
    logic [11:0]      w_qc_v;
    logic signed [12:0] w_pos_x;
    logic signed [12:0] w_pos_y;
    logic [8:0]       w_sx;
    logic [8:0]       w_sy;
    t_adv             w_adv;

    // Frame size with zero read as one and saturation at the maximum width or height.
    function automatic logic [8:0] eff_size(input logic [8:0] v, input logic [12:0] lim);
        logic [8:0] res;
        if (v == 9'd0) begin
            res = 9'd1;
        end else if (13'(v) > lim) begin
            res = 9'(lim);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= LP_W_RST;
            r_h     <= LP_H_RST;
            r_max_h <= 11'sd0;
            r_max_v <= 11'sd0;
            r_sel_h <= SEL_RED;
            r_sel_v <= SEL_GREEN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_w     <= eff_size(i_cfg_data[8:0], LP_MAXW);
                CFG_FRAME_HEIGHT: r_h     <= eff_size(i_cfg_data[8:0], LP_MAXH);
                CFG_MAX_HORIZ:    r_max_h <= $signed(i_cfg_data);
                CFG_MAX_VERT:     r_max_v <= $signed(i_cfg_data);
                CFG_HORIZ_SRC:    r_sel_h <= i_cfg_data[2:0];
                CFG_VERT_SRC:     r_sel_v <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Stage load enables: a stage loads when it is empty or its item moves on.
    always_comb begin
        w_en[NST] = !r_v[NST] || !i_out_stall;
        for (int k = NST - 1; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign w_adv = '{s2: w_en[2], s3: w_en[3], s4: w_en[4], s5: w_en[5]};

    // Input transfer; a load waits while a query has its source read ahead.
    assign w_pending  = |r_v[NST-1:1];
    assign o_in_stall = !w_en[1] || (i_in_valid && (i_mode == MODE_LOAD) && w_pending);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_inframe  = ({1'b0, i_pos_x} < r_w) && ({1'b0, i_pos_y} < r_h);
    assign w_wr       = w_acc && w_inframe && (i_mode == MODE_LOAD);
    assign w_q0       = w_acc && w_inframe && (i_mode == MODE_QUERY);
    assign w_addr_in  = AW'(i_pos_y) * LP_ROW + AW'(i_pos_x);
    assign w_wdata    = {i_in_alpha, i_in_blue, i_in_green, i_in_red};

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= w_q0;
            end
            for (int k = 2; k <= NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Query position travels with its item.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_x[1] <= i_pos_x;
            r_y[1] <= i_pos_y;
        end
        for (int k = 2; k <= NST; k++) begin
            if (w_en[k]) begin
                r_x[k] <= r_x[k-1];
                r_y[k] <= r_y[k-1];
            end
        end
    end

    // Frame memory: map read on port A, source read on port B.
    dmw_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_wr),
        .i_waddr   (w_addr_in),
        .i_wdata   (w_wdata),
        .i_re_a    (w_en[1]),
        .i_raddr_a (w_addr_in),
        .o_rdata_a (w_map),
        .i_re_b    (w_en[NST]),
        .i_raddr_b (w_addr_src),
        .o_rdata_b (w_src)
    );

    // Offset pipelines, one per axis.
    dmw_offset u_off_h (
        .i_clk   (i_clk),
        .i_pixel (w_map),
        .i_sel   (r_sel_h),
        .i_max   (r_max_h),
        .i_adv   (w_adv),
        .o_qc    (w_qc_h)
    );

    dmw_offset u_off_v (
        .i_clk   (i_clk),
        .i_pixel (w_map),
        .i_sel   (r_sel_v),
        .i_max   (r_max_v),
        .i_adv   (w_adv),
        .o_qc    (w_qc_v)
    );

    // Displaced source position, clamped to the active frame.
    assign w_pos_x = $signed({5'd0, r_x[NST-1]}) + $signed({1'b0, w_qc_h})
                   - 13'(DIV_BIAS_Q);
    assign w_pos_y = $signed({5'd0, r_y[NST-1]}) + $signed({1'b0, w_qc_v})
                   - 13'(DIV_BIAS_Q);

    always_comb begin
        if (w_pos_x < 13'sd0) begin
            w_sx = 9'd0;
        end else if (w_pos_x >= $signed({4'd0, r_w})) begin
            w_sx = r_w - 9'd1;
        end else begin
            w_sx = w_pos_x[8:0];
        end
        if (w_pos_y < 13'sd0) begin
            w_sy = 9'd0;
        end else if (w_pos_y >= $signed({4'd0, r_h})) begin
            w_sy = r_h - 9'd1;
        end else begin
            w_sy = w_pos_y[8:0];
        end
    end

    assign w_addr_src = AW'(w_sy) * LP_ROW + AW'(w_sx);

    // Result transfer comes straight from the last stage.
    assign o_out_valid = r_v[NST];
    assign o_out_x     = r_x[NST];
    assign o_out_y     = r_y[NST];
    assign o_out_red   = w_src[7:0];
    assign o_out_green = w_src[15:8];
    assign o_out_blue  = w_src[23:16];
    assign o_out_alpha = w_src[31:24];

    // A load never passes a query that still has its source read to make.
    `DMW_ASSERT_IMP(a_load_interlock, i_clk, i_rst_n, w_acc && (i_mode == MODE_LOAD), !w_pending)
    // An in-frame query enters the pipeline right after its transfer.
    `DMW_ASSERT_NXT(a_query_enters, i_clk, i_rst_n, w_q0, r_v[1])
    // The source read stays inside the active frame.
    `DMW_ASSERT_IMP(a_src_in_frame, i_clk, i_rst_n, r_v[NST-1], (w_sx < r_w) && (w_sy < r_h))

endmodule

`default_nettype wire

// ----- verif/tb_displacement_map_warp.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_displacement_map_warp
// Self-checking testbench of the displacement map warp block. Loads and
// queries go through the valid/stall input channel; a local copy of the frame
// store and of the registers works out the pixel that each query must return.
// A checker compares every output transfer with the oldest pending pixel.
// Directed tests cover reset values, channel selections, displacement
// extremes and frame bounds; random phases follow with varied settings.
// ----------------------------------------------------------------------------
module tb_displacement_map_warp;
    import dmw_pkg::*;

    localparam int FRAME_MAX = 256;
    localparam longint FULL_LEVEL = 65280;
    localparam int LUMA_R = 77;
    localparam int LUMA_G = 150;
    localparam int LUMA_B = 29;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1700;
    localparam int STEADY_ITEMS = 150;
    localparam int RUN_LIMIT_NS = 4_000_000;

    // Selection codes above alpha; all of them give luminance.
    localparam logic [2:0] SEL_LUMA  = 3'd4;
    localparam logic [2:0] SEL_HUE   = 3'd5;
    localparam logic [2:0] SEL_SAT   = 3'd6;
    localparam logic [2:0] SEL_LIGHT = 3'd7;

    localparam logic signed [10:0] SPAN_MIN = 11'h400;
    localparam logic signed [10:0] SPAN_MAX = 11'h3FF;

    typedef struct packed {
        logic [7:0] x, y, red, green, blue, alpha;
    } t_warp_pixel;

    // Block ports.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_mode = 1'b0;
    logic [7:0]            i_pos_x = '0;
    logic [7:0]            i_pos_y = '0;
    logic [7:0]            i_in_red = '0;
    logic [7:0]            i_in_green = '0;
    logic [7:0]            i_in_blue = '0;
    logic [7:0]            i_in_alpha = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [7:0]            o_out_x;
    logic [7:0]            o_out_y;
    logic [7:0]            o_out_red;
    logic [7:0]            o_out_green;
    logic [7:0]            o_out_blue;
    logic [7:0]            o_out_alpha;

    // Local copy of the frame store and the registers.
    logic [31:0]       frame_mem [0:65535];
    bit                frame_loaded [0:65535];
    logic [8:0]        reg_width = 9'd256;
    logic [8:0]        reg_height = 9'd256;
    logic signed [10:0] reg_span_h = '0;
    logic signed [10:0] reg_span_v = '0;
    logic [2:0]        reg_sel_h = SEL_RED;
    logic [2:0]        reg_sel_v = SEL_GREEN;

    t_warp_pixel   warp_results_due [$];
    logic [15:0]   loaded_spots [$];
    int unsigned   mismatches = 0;
    int unsigned   items_sent = 0;
    int unsigned   gap_odds = 4;
    int unsigned   stall_odds = 4;
    int unsigned   hold_left = 0;

    displacement_map_warp dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_in_alpha  (i_in_alpha),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // Output backpressure comes in random bursts, and none while stall_odds is zero.
    always @(negedge i_clk) begin
        if (stall_odds == 0) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(1, stall_odds) == 1) begin
            hold_left   <= $urandom_range(0, 12);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Frame arithmetic
    // ------------------------------------------------------------------------

    function automatic int active_cols();
        if (reg_width == 0) return 1;
        if (reg_width > FRAME_MAX) return FRAME_MAX;
        return int'(reg_width);
    endfunction

    function automatic int active_rows();
        if (reg_height == 0) return 1;
        if (reg_height > FRAME_MAX) return FRAME_MAX;
        return int'(reg_height);
    endfunction

    function automatic bit in_frame(logic [7:0] x, logic [7:0] y);
        return (int'(x) < active_cols()) && (int'(y) < active_rows());
    endfunction

    // Map channel as an 8.8 level.
    function automatic int channel_level(logic [31:0] px, logic [2:0] sel);
        case (sel)
            SEL_RED:   return int'(px[7:0]) * 256;
            SEL_GREEN: return int'(px[15:8]) * 256;
            SEL_BLUE:  return int'(px[23:16]) * 256;
            SEL_ALPHA: return int'(px[31:24]) * 256;
            default:   return LUMA_R * int'(px[7:0]) + LUMA_G * int'(px[15:8])
                              + LUMA_B * int'(px[23:16]);
        endcase
    endfunction

    // Whole-pixel offset, rounded toward minus infinity.
    function automatic longint shift_of(int level, logic signed [10:0] span);
        longint num;
        longint q;
        num = (2 * longint'(level) - FULL_LEVEL) * longint'(span);
        q = num / FULL_LEVEL;
        if (num % FULL_LEVEL != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    function automatic logic [7:0] clamp_axis(longint spot, int extent);
        if (spot < 0) return 8'd0;
        if (spot > extent - 1) return 8'(extent - 1);
        return 8'(spot);
    endfunction

    // Source position of a query; false when the query lies outside the frame.
    function automatic bit source_of(input logic [7:0] x, y, output logic [7:0] sx, sy);
        logic [31:0] map_px;
        sx = x;
        sy = y;
        if (!in_frame(x, y)) return 1'b0;
        map_px = frame_mem[{y, x}];
        sx = clamp_axis(longint'(x) + shift_of(channel_level(map_px, reg_sel_h), reg_span_h),
                        active_cols());
        sy = clamp_axis(longint'(y) + shift_of(channel_level(map_px, reg_sel_v), reg_span_v),
                        active_rows());
        return 1'b1;
    endfunction

    // Apply one accepted item to the local frame and queue its result.
    function automatic void process_pixel_item(logic mode, logic [7:0] x, y,
                                               logic [31:0] pixel);
        logic [7:0]  sx;
        logic [7:0]  sy;
        logic [31:0] src;
        t_warp_pixel due;
        if (!in_frame(x, y)) return;
        if (mode == MODE_LOAD) begin
            frame_mem[{y, x}] = pixel;
            frame_loaded[{y, x}] = 1'b1;
            loaded_spots.push_back({y, x});
            if (loaded_spots.size() > 64) void'(loaded_spots.pop_front());
        end else begin
            void'(source_of(x, y, sx, sy));
            src = frame_mem[{sy, sx}];
            due.x = x;
            due.y = y;
            due.red = src[7:0];
            due.green = src[15:8];
            due.blue = src[23:16];
            due.alpha = src[31:24];
            warp_results_due.push_back(due);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic compare_byte(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_warp_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (warp_results_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: result (%0d,%0d) with none expected, expected none, actual %h",
                         $time, o_out_x, o_out_y,
                         {o_out_alpha, o_out_blue, o_out_green, o_out_red});
            end else begin
                want = warp_results_due.pop_front();
                compare_byte("out_x", want.x, o_out_x);
                compare_byte("out_y", want.y, o_out_y);
                compare_byte("out_red", want.red, o_out_red);
                compare_byte("out_green", want.green, o_out_green);
                compare_byte("out_blue", want.blue, o_out_blue);
                compare_byte("out_alpha", want.alpha, o_out_alpha);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    task automatic idle_cycles(int unsigned n);
        i_in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // One input transfer; starts and ends on a falling edge.
    task automatic send_item(input logic mode, input logic [7:0] x, y,
                             input logic [7:0] red, green, blue, alpha);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            idle_cycles($urandom_range(1, 13));
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_in_red   <= red;
        i_in_green <= green;
        i_in_blue  <= blue;
        i_in_alpha <= alpha;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        process_pixel_item(mode, x, y, {alpha, blue, green, red});
        items_sent++;
        @(negedge i_clk);
    endtask

    // Wait until every pending pixel has come out and the block has settled.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (warp_results_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_FRAME_WIDTH:  reg_width = data[8:0];
            CFG_FRAME_HEIGHT: reg_height = data[8:0];
            CFG_MAX_HORIZ:    reg_span_h = data;
            CFG_MAX_VERT:     reg_span_v = data;
            CFG_HORIZ_SRC:    reg_sel_h = data[2:0];
            CFG_VERT_SRC:     reg_sel_v = data[2:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_warp(input logic [8:0] w, h, input logic signed [10:0] span_h, span_v,
                            input logic [2:0] sel_h, sel_v);
        drain_results();
        write_reg(CFG_FRAME_WIDTH, {2'b00, w});
        write_reg(CFG_FRAME_HEIGHT, {2'b00, h});
        write_reg(CFG_MAX_HORIZ, span_h);
        write_reg(CFG_MAX_VERT, span_v);
        write_reg(CFG_HORIZ_SRC, {8'd0, sel_h});
        write_reg(CFG_VERT_SRC, {8'd0, sel_v});
    endtask

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 5);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Query that first loads any pixel it would read but that was never written.
    task automatic send_warp_query(input logic [7:0] x, y);
        logic [7:0] sx;
        logic [7:0] sy;
        if (in_frame(x, y)) begin
            if (!frame_loaded[{y, x}]) begin
                send_item(MODE_LOAD, x, y, pick_byte(), pick_byte(), pick_byte(), pick_byte());
            end
            void'(source_of(x, y, sx, sy));
            if (!frame_loaded[{sy, sx}]) begin
                send_item(MODE_LOAD, sx, sy, pick_byte(), pick_byte(), pick_byte(),
                          pick_byte());
            end
        end
        send_item(MODE_QUERY, x, y, pick_byte(), pick_byte(), pick_byte(), pick_byte());
    endtask

    // ------------------------------------------------------------------------
    // Random choices
    // ------------------------------------------------------------------------

    // Mostly small frames, with zero, full and oversized widths now and then.
    function automatic logic [8:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 10) return 9'($urandom_range(1, 8));
        if (r < 15) return 9'($urandom_range(9, 64));
        if (r == 15) return 9'd0;
        if (r == 16) return 9'd256;
        if (r == 17) return 9'($urandom_range(257, 511));
        return 9'($urandom_range(1, 256));
    endfunction

    function automatic logic signed [10:0] pick_span();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return SPAN_MIN;
        if (r == 1) return SPAN_MAX;
        if (r == 2) return 11'sd0;
        if (r < 7) return 11'(int'($urandom_range(0, 32)) - 16);
        return 11'(int'($urandom_range(0, 2047)) - 1024);
    endfunction

    function automatic int unsigned pick_odds();
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(2, 10);
    endfunction

    function automatic logic [7:0] pick_col();
        return 8'($urandom_range(0, active_cols() - 1));
    endfunction

    function automatic logic [7:0] pick_row();
        return 8'($urandom_range(0, active_rows() - 1));
    endfunction

    task automatic random_item();
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] spot;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if ($urandom_range(0, 4) == 0) begin
                x = 8'($urandom_range(0, 255));
                y = 8'($urandom_range(0, 255));
            end else begin
                x = pick_col();
                y = pick_row();
            end
            send_item(MODE_LOAD, x, y, pick_byte(), pick_byte(), pick_byte(), pick_byte());
        end else begin
            if (pick < 75 && loaded_spots.size() != 0) begin
                spot = loaded_spots[$urandom_range(0, loaded_spots.size() - 1)];
                x = spot[7:0];
                y = spot[15:8];
            end else if (pick < 92) begin
                x = pick_col();
                y = pick_row();
            end else begin
                x = 8'($urandom_range(0, 255));
                y = 8'($urandom_range(0, 255));
            end
            send_warp_query(x, y);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: full frame, no displacement, so each query returns itself.
    task automatic test_reset_values();
        send_item(MODE_LOAD, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(MODE_LOAD, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(MODE_LOAD, 8'd255, 8'd0, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
        send_warp_query(8'd0, 8'd0);
        send_warp_query(8'd255, 8'd255);
        send_warp_query(8'd255, 8'd0);
        drain_results();
    endtask

    // Two by two frame: every channel, both displacement extremes, luminance
    // codes and items that fall outside the frame.
    task automatic test_channels_and_extremes();
        set_warp(9'd2, 9'd2, SPAN_MAX, SPAN_MIN, SEL_RED, SEL_GREEN);
        send_item(MODE_LOAD, 8'd0, 8'd0, 8'hFF, 8'h00, 8'h00, 8'hFF);
        send_item(MODE_LOAD, 8'd1, 8'd0, 8'h00, 8'hFF, 8'hFF, 8'h00);
        send_item(MODE_LOAD, 8'd0, 8'd1, 8'h80, 8'h7F, 8'h01, 8'hFE);
        send_item(MODE_LOAD, 8'd1, 8'd1, 8'h7F, 8'h80, 8'hFE, 8'h01);
        send_warp_query(8'd0, 8'd0);
        send_warp_query(8'd1, 8'd0);
        send_warp_query(8'd0, 8'd1);
        send_warp_query(8'd1, 8'd1);

        set_warp(9'd2, 9'd2, SPAN_MIN, SPAN_MAX, SEL_ALPHA, SEL_BLUE);
        send_warp_query(8'd0, 8'd0);
        send_warp_query(8'd1, 8'd1);

        set_warp(9'd2, 9'd2, 11'sd3, -11'sd2, SEL_LIGHT, SEL_LUMA);
        send_warp_query(8'd1, 8'd0);
        send_warp_query(8'd0, 8'd1);

        // Outside the frame: the load is dropped and the query gives nothing.
        send_item(MODE_LOAD, 8'd2, 8'd0, 8'h12, 8'h34, 8'h56, 8'h78);
        send_item(MODE_QUERY, 8'd0, 8'd2, 8'h00, 8'h00, 8'h00, 8'h00);
        drain_results();
    endtask

    // A zero size acts as one; oversized widths and heights saturate.
    task automatic test_frame_bounds();
        set_warp(9'd0, 9'd0, 11'sd0, 11'sd0, SEL_BLUE, SEL_LUMA);
        send_item(MODE_LOAD, 8'd1, 8'd0, 8'h11, 8'h22, 8'h33, 8'h44);
        send_item(MODE_QUERY, 8'd1, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_warp_query(8'd0, 8'd0);

        // The dropped load must not have touched the pixel stored earlier.
        set_warp(9'd300, 9'd511, 11'sd0, 11'sd0, SEL_HUE, SEL_SAT);
        send_warp_query(8'd1, 8'd0);
        send_warp_query(8'd255, 8'd255);
        drain_results();
    endtask

    // Phases of random settings, random idling and occasional full drains.
    task automatic test_random_mix();
        int unsigned target;
        int unsigned phase_len;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            drain_results();
            gap_odds = pick_odds();
            stall_odds = pick_odds();
            set_warp(pick_size(), pick_size(), pick_span(), pick_span(),
                     3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            phase_len = $urandom_range(60, 220);
            repeat (phase_len) begin
                if (items_sent >= target) break;
                if ($urandom_range(0, 149) == 0) drain_results();
                random_item();
            end
        end
        drain_results();
    endtask

    // Full rate on both sides at the end of the run.
    task automatic test_steady_stream();
        int unsigned target;
        gap_odds = 0;
        stall_odds = 0;
        set_warp(9'd16, 9'd16, pick_span(), pick_span(),
                 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        target = items_sent + STEADY_ITEMS;
        while (items_sent < target) begin
            random_item();
        end
        drain_results();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_channels_and_extremes();
        test_frame_bounds();
        test_random_mix();
        test_steady_stream();
        if (mismatches == 0 && warp_results_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- displacement_map_warp.f -----
+incdir+sv
sv/dmw_pkg.sv
sv/dmw_frame_mem.sv
sv/dmw_offset.sv
sv/displacement_map_warp.sv
verif/tb_displacement_map_warp.sv
